// File: hdl/s8d_pkg.sv
`default_nettype none

package s8d_pkg;

    // Frame markers and layout
    localparam logic [7:0] SYNC_HI   = 8'hFF;
    localparam logic [7:0] SYNC_LO   = 8'hFE;
    localparam logic [7:0] TAIL_HI   = 8'hFD;
    localparam logic [7:0] TAIL_LO   = 8'hFC;
    localparam logic [7:0] MIN_LEN   = 8'd8;
    localparam logic [7:0] CHK_BACK  = 8'd3;
    localparam logic [8:0] HDR_BYTES = 9'd5;

    // Window read offset selects
    typedef logic [3:0] rd_sel_t;
    localparam rd_sel_t RD_OFS0     = 4'd0;
    localparam rd_sel_t RD_OFS1     = 4'd1;
    localparam rd_sel_t RD_OFS2     = 4'd2;
    localparam rd_sel_t RD_OFS3     = 4'd3;
    localparam rd_sel_t RD_OFS4     = 4'd4;
    localparam rd_sel_t RD_HDR      = 4'd5;
    localparam rd_sel_t RD_LEN_M2   = 4'd6;
    localparam rd_sel_t RD_LEN_M1   = 4'd7;
    localparam rd_sel_t RD_SUM_NEXT = 4'd8;
    localparam rd_sel_t RD_PAY      = 4'd9;
    localparam rd_sel_t RD_PAY_NEXT = 4'd10;

    typedef struct packed {
        logic    wr;
        logic    drop_one;
        logic    drop_len;
        rd_sel_t rd_sel;
        logic    cap_len;
        logic    clr_sum;
        logic    acc_sum;
        logic    cap_seq;
        logic    cap_cmd;
        logic    init_pay;
        logic    pay_byte;
        logic    load_out;
        logic    next_word;
    } s8d_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic fill_lt2;
        logic fill_lt3;
        logic is_ff;
        logic is_fe;
        logic len_bad;
        logic len_wait;
        logic is_fd;
        logic is_fc;
        logic sum_ok;
        logic sum_done;
        logic plen_zero;
        logic word_done;
        logic is_last;
        logic out_full;
    } s8d_sts_t;

endpackage

`default_nettype wire

// File: hdl/s8d_ram.sv
`default_nettype none

module s8d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/s8d_datapath.sv
`default_nettype none

module s8d_datapath
    import s8d_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int WORD_BYTES   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire s8d_cmd_t    cmd,
    output s8d_sts_t         sts,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [7:0]       seq_number,
    output logic [7:0]       command_code,
    output logic [63:0]      payload_word,
    output logic [3:0]       valid_bytes,
    output logic             first_word,
    output logic             last_word
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);

    // head + offset, folded back into the window (sum is always below 2*depth)
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [8:0] off);
        logic [9:0] s;
        s = {{(10-AW){1'b0}}, base} + {1'b0, off};
        if (s >= 10'(WINDOW_DEPTH))
        begin
            s = s - 10'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]  len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  sidx_reg, sidx_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  cmdb_reg, cmdb_next;
    logic [7:0]  pidx_reg, pidx_next;
    logic [63:0] asm_reg, asm_next;
    logic [3:0]  jcnt_reg, jcnt_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;

    logic [7:0]  oseq_reg, oseq_next;
    logic [7:0]  ocmd_reg, ocmd_next;
    logic [63:0] oword_reg, oword_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic        ofirst_reg, ofirst_next;
    logic        olast_reg, olast_next;

    logic [7:0]    win_rdata;
    logic [AW-1:0] win_raddr;
    logic [AW-1:0] win_waddr;
    logic [8:0]    rd_off;
    logic [8:0]    fill9;
    logic [7:0]    plen;

    assign fill9     = 9'(fill_reg);
    assign plen      = len_reg - MIN_LEN;
    assign win_waddr = wrap(head_reg, fill9);
    assign win_raddr = wrap(head_reg, rd_off);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_OFS0:     rd_off = 9'd0;
            RD_OFS1:     rd_off = 9'd1;
            RD_OFS2:     rd_off = 9'd2;
            RD_OFS3:     rd_off = 9'd3;
            RD_OFS4:     rd_off = 9'd4;
            RD_HDR:      rd_off = HDR_BYTES;
            RD_LEN_M2:   rd_off = 9'(win_rdata) - 9'd2;
            RD_LEN_M1:   rd_off = 9'(len_reg) - 9'd1;
            RD_SUM_NEXT: rd_off = 9'(sidx_reg) + 9'd1;
            RD_PAY:      rd_off = HDR_BYTES + 9'(pidx_reg);
            RD_PAY_NEXT: rd_off = HDR_BYTES + 9'(pidx_reg) + 9'd1;
            default:     rd_off = 9'd0;
        endcase
    end

    s8d_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (win_waddr),
        .wdata (rx_byte),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    always_comb
    begin
        sts.fill_zero = (fill9 == 9'd0);
        sts.fill_lt2  = (fill9 < 9'd2);
        sts.fill_lt3  = (fill9 < 9'd3);
        sts.is_ff     = (win_rdata == SYNC_HI);
        sts.is_fe     = (win_rdata == SYNC_LO);
        sts.len_bad   = (win_rdata < MIN_LEN) || (9'(win_rdata) > 9'(WINDOW_DEPTH));
        sts.len_wait  = (fill9 < 9'(win_rdata));
        sts.is_fd     = (win_rdata == TAIL_HI);
        sts.is_fc     = (win_rdata == TAIL_LO);
        sts.sum_ok    = (win_rdata == sum_reg);
        sts.sum_done  = ((sidx_reg + 8'd1) == (len_reg - CHK_BACK));
        sts.plen_zero = (plen == 8'd0);
        sts.word_done = (jcnt_reg == 4'(WORD_BYTES - 1)) || ((pidx_reg + 8'd1) == plen);
        sts.is_last   = last_reg;
        sts.out_full  = out_valid_reg;
    end

    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        sidx_next      = sidx_reg;
        seq_next       = seq_reg;
        cmdb_next      = cmdb_reg;
        pidx_next      = pidx_reg;
        asm_next       = asm_reg;
        jcnt_next      = jcnt_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        oseq_next      = oseq_reg;
        ocmd_next      = ocmd_reg;
        oword_next     = oword_reg;
        ocnt_next      = ocnt_reg;
        ofirst_next    = ofirst_reg;
        olast_next     = olast_reg;

        if (cmd.wr)
        begin
            // a full window loses its oldest byte to make room
            if (fill9 == 9'(WINDOW_DEPTH))
            begin
                head_next = wrap(head_reg, 9'd1);
            end
            else
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
        if (cmd.drop_one)
        begin
            head_next = wrap(head_reg, 9'd1);
            fill_next = fill_reg - FW'(1);
        end
        if (cmd.drop_len)
        begin
            head_next = wrap(head_reg, 9'(len_reg));
            fill_next = fill_reg - FW'(len_reg);
        end

        if (cmd.cap_len)
        begin
            len_next = win_rdata;
        end
        if (cmd.clr_sum)
        begin
            sum_next  = 8'd0;
            sidx_next = 8'd0;
        end
        if (cmd.acc_sum)
        begin
            sum_next  = sum_reg + win_rdata;
            sidx_next = sidx_reg + 8'd1;
        end
        if (cmd.cap_seq)
        begin
            seq_next = win_rdata;
        end
        if (cmd.cap_cmd)
        begin
            cmdb_next = win_rdata;
        end

        if (cmd.init_pay)
        begin
            asm_next   = 64'd0;
            jcnt_next  = 4'd0;
            pidx_next  = 8'd0;
            first_next = 1'b1;
            last_next  = (plen == 8'd0);
        end
        if (cmd.pay_byte)
        begin
            for (int l = 0; l < 8; l++)
            begin
                if (4'(l) == jcnt_reg)
                begin
                    asm_next[8*l +: 8] = win_rdata;
                end
            end
            jcnt_next = jcnt_reg + 4'd1;
            pidx_next = pidx_reg + 8'd1;
            last_next = ((pidx_reg + 8'd1) == plen);
        end
        if (cmd.next_word)
        begin
            asm_next   = 64'd0;
            jcnt_next  = 4'd0;
            first_next = 1'b0;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            oseq_next      = seq_reg;
            ocmd_next      = cmdb_reg;
            oword_next     = asm_reg;
            ocnt_next      = jcnt_reg;
            ofirst_next    = first_reg;
            olast_next     = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        sum_reg    <= sum_next;
        sidx_reg   <= sidx_next;
        seq_reg    <= seq_next;
        cmdb_reg   <= cmdb_next;
        pidx_reg   <= pidx_next;
        asm_reg    <= asm_next;
        jcnt_reg   <= jcnt_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        oseq_reg   <= oseq_next;
        ocmd_reg   <= ocmd_next;
        oword_reg  <= oword_next;
        ocnt_reg   <= ocnt_next;
        ofirst_reg <= ofirst_next;
        olast_reg  <= olast_next;
    end

    assign out_valid    = out_valid_reg;
    assign seq_number   = oseq_reg;
    assign command_code = ocmd_reg;
    assign payload_word = oword_reg;
    assign valid_bytes  = ocnt_reg;
    assign first_word   = ofirst_reg;
    assign last_word    = olast_reg;

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg)
        else $error("result loaded over a pending request");

    a_drop_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_len |-> (9'(len_reg) <= fill9))
        else $error("frame removal longer than window fill");

    a_drop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop_len |=> (fill_reg == $past(fill_reg) - FW'($past(len_reg))))
        else $error("fill not reduced by frame length");

    a_wr_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr && (fill9 < 9'(WINDOW_DEPTH))) |=> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("byte write did not grow the window");

endmodule

`default_nettype wire

// File: hdl/s8d_ctrl.sv
`default_nettype none

module s8d_ctrl
    import s8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire s8d_sts_t sts,
    output s8d_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CK0  = 4'd2;
    localparam logic [3:0] S_CK1  = 4'd3;
    localparam logic [3:0] S_CKL  = 4'd4;
    localparam logic [3:0] S_CKT0 = 4'd5;
    localparam logic [3:0] S_CKT1 = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_CKS  = 4'd8;
    localparam logic [3:0] S_SEQ  = 4'd9;
    localparam logic [3:0] S_CMD  = 4'd10;
    localparam logic [3:0] S_PAY  = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0] state_reg, state_next;

    // Each check state consumes the window byte addressed by the state before it.
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_OFS0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.wr     = 1'b1;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                if (sts.fill_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_OFS0;
                    state_next = S_CK0;
                end
            end
            S_CK0:
            begin
                if (!sts.is_ff)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else if (sts.fill_lt2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_OFS1;
                    state_next = S_CK1;
                end
            end
            S_CK1:
            begin
                if (!sts.is_fe)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else if (sts.fill_lt3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_OFS2;
                    state_next = S_CKL;
                end
            end
            S_CKL:
            begin
                cmd.cap_len = 1'b1;
                if (sts.len_bad)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else if (sts.len_wait)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_LEN_M2;
                    state_next = S_CKT0;
                end
            end
            S_CKT0:
            begin
                if (!sts.is_fd)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else
                begin
                    cmd.rd_sel = RD_LEN_M1;
                    state_next = S_CKT1;
                end
            end
            S_CKT1:
            begin
                if (!sts.is_fc)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else
                begin
                    cmd.clr_sum = 1'b1;
                    cmd.rd_sel  = RD_OFS0;
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                // the read after the last summed byte lands on the checksum itself
                cmd.acc_sum = 1'b1;
                cmd.rd_sel  = RD_SUM_NEXT;
                if (sts.sum_done)
                begin
                    state_next = S_CKS;
                end
            end
            S_CKS:
            begin
                if (!sts.sum_ok)
                begin
                    cmd.drop_one = 1'b1;
                    state_next   = S_RD0;
                end
                else
                begin
                    cmd.rd_sel = RD_OFS3;
                    state_next = S_SEQ;
                end
            end
            S_SEQ:
            begin
                cmd.cap_seq = 1'b1;
                cmd.rd_sel  = RD_OFS4;
                state_next  = S_CMD;
            end
            S_CMD:
            begin
                cmd.cap_cmd  = 1'b1;
                cmd.init_pay = 1'b1;
                if (sts.plen_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_sel = RD_HDR;
                    state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                cmd.pay_byte = 1'b1;
                if (sts.word_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_sel = RD_PAY_NEXT;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.is_last)
                    begin
                        cmd.drop_len = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        cmd.rd_sel    = RD_PAY;
                        state_next    = S_PAY;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/sum8_packet_deframer.sv
// Length-prefixed frame parser with an 8-bit additive checksum.
//
// Input: one received byte per request on rx_byte (in_valid / in_ready).
// Output: one payload word per request (out_valid / out_ready) carrying the
// frame's seq_number and command_code, up to WORD_BYTES payload bytes in
// payload_word (earliest byte in bits 7:0), valid_bytes, first_word and
// last_word. An empty payload gives a single word with valid_bytes of 0.
//
// Bytes sit in a WINDOW_DEPTH-entry RAM window. After each byte the front
// of the window is checked through the single RAM read port, one byte at
// a time; a complete frame of length L gives one or more words (one for an
// empty payload), and the next byte is taken only once the check and its
// words are done. Each rejected candidate drops one front byte, and the
// front of the window is rescanned byte by byte.
//
// Reset empties the window and the result register; no clearing pass.
// A stalled receiver holds the finished word in the output register; after
// a frame's last word, input is still taken until the next word needs that register.
`default_nettype none

module sum8_packet_deframer
    import s8d_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int WORD_BYTES   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       seq_number,
    output logic [7:0]       command_code,
    output logic [63:0]      payload_word,
    output logic [3:0]       valid_bytes,
    output logic             first_word,
    output logic             last_word
);

    s8d_cmd_t cmd;
    s8d_sts_t sts;

    s8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    s8d_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .WORD_BYTES   (WORD_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .rx_byte      (rx_byte),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .seq_number   (seq_number),
        .command_code (command_code),
        .payload_word (payload_word),
        .valid_bytes  (valid_bytes),
        .first_word   (first_word),
        .last_word    (last_word)
    );

endmodule

`default_nettype wire

// File: tb/sv/s8d_frame_checker.sv
`timescale 1ns / 1ps

module s8d_frame_checker
    import s8d_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int WORD_BYTES   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [7:0]  seq_number,
    input  wire logic [7:0]  command_code,
    input  wire logic [63:0] payload_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        first_word,
    input  wire logic        last_word,
    output int               mismatches,
    output int               words_due
);

    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int LEN_OFS = 2;
    localparam int SEQ_OFS = 3;
    localparam int CMD_OFS = 4;

    typedef struct packed {
        logic [7:0]  seq;
        logic [7:0]  cmd;
        logic [63:0] data;
        logic [3:0]  count;
        logic        first;
        logic        last;
    } pay_word_t;

    logic [7:0]       win_mem [WINDOW_DEPTH];
    logic [PTR_W-1:0] win_head;
    logic [PTR_W:0]   win_fill;
    pay_word_t        words_owed[$];

    initial
    begin
        mismatches = 0;
        words_due  = 0;
        win_head   = '0;
        win_fill   = '0;
    end

    function automatic logic [7:0] win_peek(input int ofs);
        return win_mem[(int'(win_head) + ofs) % WINDOW_DEPTH];
    endfunction

    task automatic win_discard(input int n);
        if (n > int'(win_fill))
            n = int'(win_fill);
        win_head = PTR_W'((int'(win_head) + n) % WINDOW_DEPTH);
        win_fill = win_fill - (PTR_W+1)'(n);
    endtask

    // Split the payload of the frame at the window front into words
    task automatic queue_frame_words(input int len);
        int plen;
        int nwords;
        int cnt;
        pay_word_t w;
        plen   = len - int'(MIN_LEN);
        nwords = (plen == 0) ? 1 : (plen + WORD_BYTES - 1) / WORD_BYTES;
        for (int k = 0; k < nwords; k++)
        begin
            cnt = plen - k * WORD_BYTES;
            if (cnt > WORD_BYTES)
                cnt = WORD_BYTES;
            w       = '0;
            w.seq   = win_peek(SEQ_OFS);
            w.cmd   = win_peek(CMD_OFS);
            w.count = 4'(cnt);
            w.first = (k == 0);
            w.last  = (k == nwords - 1);
            for (int j = 0; j < cnt; j++)
                w.data[8*j +: 8] = win_peek(int'(HDR_BYTES) + k * WORD_BYTES + j);
            words_owed.push_back(w);
        end
    endtask

    // Append one byte, then rescan the front until it waits or a frame is taken
    task automatic take_byte(input logic [7:0] b);
        int         len;
        logic [7:0] sum;
        bit         done;
        if (int'(win_fill) >= WINDOW_DEPTH)
            win_discard(1);
        win_mem[(int'(win_head) + int'(win_fill)) % WINDOW_DEPTH] = b;
        win_fill++;
        done = 1'b0;
        while (!done && win_fill != 0)
        begin
            if (win_peek(0) != SYNC_HI)
                win_discard(1);
            else if (win_fill < 2)
                done = 1'b1;
            else if (win_peek(1) != SYNC_LO)
                win_discard(1);
            else if (win_fill < 3)
                done = 1'b1;
            else
            begin
                len = int'(win_peek(LEN_OFS));
                if (len < int'(MIN_LEN) || len > WINDOW_DEPTH)
                    win_discard(1);
                else if (int'(win_fill) < len)
                    done = 1'b1;
                else
                begin
                    sum = '0;
                    for (int i = 0; i + int'(CHK_BACK) < len; i++)
                        sum += win_peek(i);
                    if (win_peek(len - 2) != TAIL_HI || win_peek(len - 1) != TAIL_LO
                        || win_peek(len - int'(CHK_BACK)) != sum)
                        win_discard(1);
                    else
                    begin
                        // at most one frame per byte; any backlog waits for the next
                        queue_frame_words(len);
                        win_discard(len);
                        done = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
    endtask

    task automatic check_word();
        pay_word_t want;
        if (words_owed.size() == 0)
            report_mismatch("word with none owed", payload_word, '0);
        else
        begin
            want = words_owed.pop_front();
            if (seq_number !== want.seq)
                report_mismatch("seq_number", seq_number, want.seq);
            if (command_code !== want.cmd)
                report_mismatch("command_code", command_code, want.cmd);
            if (payload_word !== want.data)
                report_mismatch("payload_word", payload_word, want.data);
            if (valid_bytes !== want.count)
                report_mismatch("valid_bytes", valid_bytes, want.count);
            if (first_word !== want.first)
                report_mismatch("first_word", first_word, want.first);
            if (last_word !== want.last)
                report_mismatch("last_word", last_word, want.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_word();
            if (in_valid && in_ready)
                take_byte(rx_byte);
            words_due = words_owed.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import s8d_pkg::*;
;

    localparam int WINDOW_DEPTH = 256;
    localparam int WORD_BYTES   = 8;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_BYTES = 310;
    localparam int MAX_PLEN     = 255 - int'(MIN_LEN);
    localparam int LEN_POS      = 2;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_TAIL,
        FLAW_SHORT,
        FLAW_CUT
    } flaw_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  seq_number;
    logic [7:0]  command_code;
    logic [63:0] payload_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;

    int mismatches;
    int words_due;
    int send_idle_pct = 16;
    int recv_idle_pct = 61;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int phase_start   = 0;

    logic [7:0] tx_frame[$];

    sum8_packet_deframer #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .WORD_BYTES   (WORD_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seq_number   (seq_number),
        .command_code (command_code),
        .payload_word (payload_word),
        .valid_bytes  (valid_bytes),
        .first_word   (first_word),
        .last_word    (last_word)
    );

    s8d_frame_checker #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .WORD_BYTES   (WORD_BYTES)
    ) frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seq_number   (seq_number),
        .command_code (command_code),
        .payload_word (payload_word),
        .valid_bytes  (valid_bytes),
        .first_word   (first_word),
        .last_word    (last_word),
        .mismatches   (mismatches),
        .words_due    (words_due)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Returns at the edge where the request is taken; valid stays up until
    // the next call or pause decides otherwise
    task automatic push_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_due != 0)
            @(negedge clk);
    endtask

    // pad < 0 gives random payload bytes
    task automatic build_frame(input int plen, input logic [7:0] seq, input logic [7:0] cmd,
                               input int pad);
        logic [7:0] sum;
        tx_frame = {SYNC_HI, SYNC_LO, 8'(plen + int'(MIN_LEN)), seq, cmd};
        for (int i = 0; i < plen; i++)
            tx_frame.push_back((pad < 0) ? 8'($urandom) : 8'(pad));
        sum = '0;
        foreach (tx_frame[i])
            sum += tx_frame[i];
        tx_frame.push_back(sum);
        tx_frame.push_back(TAIL_HI);
        tx_frame.push_back(TAIL_LO);
    endtask

    task automatic push_frame();
        foreach (tx_frame[i])
            push_byte(tx_frame[i]);
    endtask

    task automatic send_frame(input int plen, input flaw_t flaw, input int pad);
        int n;
        build_frame(plen, 8'($urandom), 8'($urandom), pad);
        n = tx_frame.size();
        case (flaw)
            FLAW_SUM:   tx_frame[n - 3] ^= 8'($urandom_range(1, 255));
            FLAW_TAIL:  tx_frame[n - $urandom_range(1, 2)] ^= 8'($urandom_range(1, 255));
            FLAW_SHORT: tx_frame[LEN_POS] = 8'($urandom_range(0, int'(MIN_LEN) - 1));
            FLAW_CUT:   repeat ($urandom_range(1, n - 3)) void'(tx_frame.pop_back());
            default:    ;
        endcase
        push_frame();
    endtask

    task automatic random_item();
        int pick;
        int plen;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            plen = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
            send_frame(plen, FLAW_NONE, -1);
        end
        else if (pick < 57)
            send_frame($urandom_range(60, MAX_PLEN), FLAW_NONE, -1);
        else if (pick < 70)
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
        else if (pick < 85)
            send_frame($urandom_range(0, 24), flaw_t'($urandom_range(FLAW_SUM, FLAW_CUT)), -1);
        else if (pick < 93)
        begin
            // stray header whose length swallows the next frame; rescan finds it late
            push_byte(SYNC_HI);
            push_byte(SYNC_LO);
            push_byte(8'($urandom_range(20, 80)));
            send_frame($urandom_range(0, 16), FLAW_NONE, -1);
        end
        else
            send_frame($urandom_range(0, 16), FLAW_NONE,
                       ($urandom_range(0, 1) != 0) ? int'(SYNC_HI) : int'(TAIL_HI));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // noise, empty payload, short length, one-byte payload
        push_byte(8'h00);
        build_frame(0, 8'h00, 8'hFF, -1);
        push_frame();
        push_byte(SYNC_HI);
        push_byte(SYNC_LO);
        push_byte(MIN_LEN - 8'd1);
        build_frame(1, 8'hFF, 8'h00, 255);
        push_frame();
        hold_until_drained();
        bytes_sent = 0;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 16; recv_idle_pct = 61; end
                1:       begin send_idle_pct = 61; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_BYTES / 3)
                random_item();
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: sum8_packet_deframer.f
hdl/s8d_pkg.sv
hdl/s8d_ram.sv
hdl/s8d_datapath.sv
hdl/s8d_ctrl.sv
hdl/sum8_packet_deframer.sv
tb/sv/s8d_frame_checker.sv
tb/sv/tb_top.sv
